@@ sv/key_scan_repeat_long_press_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the key scanner
// ---------------------------------------------------------------------------
`ifndef KEY_SCAN_REPEAT_LONG_PRESS_MACROS_SVH
`define KEY_SCAN_REPEAT_LONG_PRESS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KSRLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ksrlp_pkg.sv @@
// ---------------------------------------------------------------------------
// ksrlp_pkg
// Types and constants of the key scanner with auto-repeat and long press.
// ---------------------------------------------------------------------------
`default_nettype none

package ksrlp_pkg;

    localparam int MASK_W  = 3;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int TDATA_W = 8;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_REPEAT = 2'd2,
        EV_LONG   = 2'd3
    } t_event_kind;

    typedef enum logic [IDX_W-1:0] {
        CFG_PRESS_THRESHOLD    = 2'd0,
        CFG_REPEAT_RELOAD      = 2'd1,
        CFG_LONG_PRESS_REPEATS = 2'd2
    } t_cfg_index;

    localparam logic [CFG_W-1:0] PRESS_THRESHOLD_RST    = 8'd100;
    localparam logic [CFG_W-1:0] REPEAT_RELOAD_RST      = 8'd90;
    localparam logic [CFG_W-1:0] LONG_PRESS_REPEATS_RST = 8'd30;

    // key_mask in the low bits, event_kind above it
    typedef struct packed {
        t_event_kind             event_kind;
        logic [MASK_W-1:0]       key_mask;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

@@ sv/key_scan_repeat_long_press.sv @@
// ---------------------------------------------------------------------------
// key_scan_repeat_long_press
// Button scanner: press confirmation, short press, auto-repeat, long press.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one scan tick per item; tdata[2:0] is the pressed mask
//   (bit0 switch, bit1 up, bit2 down). m_axis returns exactly one item per
//   tick: tdata[2:0] key_mask, tdata[4:3] event_kind (0 none, 1 short press,
//   2 repeat, 3 long press).
//   Each result is registered in the result register, or in the skid
//   register while m_axis stalls. Throughput: one tick per cycle while
//   s_axis_tready is high; the scan state is updated in a single pass of
//   short logic from the accepted tick into the output stage.
//   Stall: a two-entry output stage (result register plus skid register)
//   keeps s_axis_tready high while one result waits; tready drops only when
//   both entries are full and returns once m_axis takes an item.
//   Reset (synchronous, i_rst_n low): scan state clears, both output entries
//   empty, registers return to threshold 100, reload 90, long-press repeats 30.
//   Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
//   high; write only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "key_scan_repeat_long_press_macros.svh"

module key_scan_repeat_long_press (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ksrlp_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ksrlp_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] pressed_mask, [7:3] zero
    input  wire logic [ksrlp_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [2:0] key_mask, [4:3] event_kind, [7:5] zero
    output logic [ksrlp_pkg::TDATA_W-1:0]        m_axis_tdata
);

    logic [ksrlp_pkg::CFG_W-1:0]   r_press_threshold;
    logic [ksrlp_pkg::CFG_W-1:0]   r_repeat_reload;
    logic [ksrlp_pkg::CFG_W-1:0]   r_long_press_repeats;

    logic [ksrlp_pkg::MASK_W-1:0]  r_previous_mask,  n_previous_mask;
    logic [ksrlp_pkg::COUNT_W-1:0] r_hold_count,     n_hold_count;
    logic [ksrlp_pkg::COUNT_W-1:0] r_repeat_count,   n_repeat_count;
    logic [ksrlp_pkg::MASK_W-1:0]  r_latched_mask,   n_latched_mask;
    logic                          r_down,           n_down;
    logic                          r_repeating,      n_repeating;

    logic                          r_out_valid;
    ksrlp_pkg::t_result            r_out_data;
    logic                          r_skid_valid;
    ksrlp_pkg::t_result            r_skid_data;

    logic                          in_accept;
    logic                          out_accept;
    logic [ksrlp_pkg::MASK_W-1:0]  in_mask;
    logic [ksrlp_pkg::COUNT_W-1:0] hold_inc;
    ksrlp_pkg::t_result            n_result;

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = r_out_valid && m_axis_tready;
    assign in_mask       = s_axis_tdata[ksrlp_pkg::MASK_W-1:0];
    assign hold_inc      = r_hold_count + ksrlp_pkg::COUNT_W'(1);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ksrlp_pkg::TDATA_W - ksrlp_pkg::RESULT_W){1'b0}}, r_out_data};

    // Scan state update for one tick
    always_comb begin
        n_previous_mask     = r_previous_mask;
        n_hold_count        = r_hold_count;
        n_repeat_count      = r_repeat_count;
        n_latched_mask      = r_latched_mask;
        n_down              = r_down;
        n_repeating         = r_repeating;
        n_result.key_mask   = '0;
        n_result.event_kind = ksrlp_pkg::EV_NONE;

        if (in_mask != '0) begin
            if (r_previous_mask == in_mask) begin
                if (hold_inc < r_press_threshold) begin
                    n_hold_count = hold_inc;
                    if (!r_repeating) begin
                        n_down         = 1'b1;
                        n_latched_mask = in_mask;
                    end
                end else begin
                    n_repeating         = 1'b1;
                    n_result.key_mask   = in_mask;
                    n_result.event_kind = (r_repeat_count == r_long_press_repeats) ?
                                          ksrlp_pkg::EV_LONG : ksrlp_pkg::EV_REPEAT;
                    n_repeat_count      = r_repeat_count + ksrlp_pkg::COUNT_W'(1);
                    n_hold_count        = r_repeat_reload;
                end
            end
            n_previous_mask = in_mask;
        end else begin
            // release: report a short press unless repeat started, then clear
            if (r_down && !r_repeating) begin
                n_result.key_mask   = r_latched_mask;
                n_result.event_kind = ksrlp_pkg::EV_SHORT;
            end
            n_down          = 1'b0;
            n_repeating     = 1'b0;
            n_hold_count    = '0;
            n_repeat_count  = '0;
            n_previous_mask = '0;
            n_latched_mask  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_threshold    <= ksrlp_pkg::PRESS_THRESHOLD_RST;
            r_repeat_reload      <= ksrlp_pkg::REPEAT_RELOAD_RST;
            r_long_press_repeats <= ksrlp_pkg::LONG_PRESS_REPEATS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ksrlp_pkg::CFG_PRESS_THRESHOLD:    r_press_threshold    <= i_cfg_data;
                ksrlp_pkg::CFG_REPEAT_RELOAD:      r_repeat_reload      <= i_cfg_data;
                ksrlp_pkg::CFG_LONG_PRESS_REPEATS: r_long_press_repeats <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_mask <= '0;
            r_hold_count    <= '0;
            r_repeat_count  <= '0;
            r_latched_mask  <= '0;
            r_down          <= 1'b0;
            r_repeating     <= 1'b0;
        end else if (in_accept) begin
            r_previous_mask <= n_previous_mask;
            r_hold_count    <= n_hold_count;
            r_repeat_count  <= n_repeat_count;
            r_latched_mask  <= n_latched_mask;
            r_down          <= n_down;
            r_repeating     <= n_repeating;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_accept) begin
                // advance skid first, else load the new item directly
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_accept) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_result;
        end
        if (in_accept && !(!r_out_valid || out_accept)) begin
            r_skid_data <= n_result;
        end else if (in_accept && r_skid_valid) begin
            r_skid_data <= n_result;
        end
    end

    `KSRLP_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry holds an item while the result register is empty")

    `KSRLP_ASSERT_NOW(a_repeat_count_needs_repeat, i_clk, i_rst_n, r_repeat_count != '0,
        r_repeating, "repeat count nonzero without auto-repeat active")

    `KSRLP_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n,
        in_accept && (in_mask == '0),
        (r_hold_count == '0) && !r_down && !r_repeating && (r_previous_mask == '0),
        "release tick did not clear the scan state")

    `KSRLP_ASSERT_NEXT(a_accept_fills_output, i_clk, i_rst_n, in_accept, r_out_valid,
        "accepted tick left no result pending")

endmodule

`default_nettype wire
